### rtl/midpoint_circle_rasterizer_core_assert.svh
// Assertion macros shared by the rasterizer RTL.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence holds in the same cycle as the condition.
`define MCR_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("rasterizer assertion failed");

// The consequence holds in the cycle after the condition.
`define MCR_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("rasterizer assertion failed");

`else

`define MCR_ASSERT_SAME(label, clk, rst, cond, cons)
`define MCR_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

### rtl/mcr_pkg.sv
package mcr_pkg;

   // Item kinds on the request side.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Eight symmetric points per step.
   localparam int OCT_BITS = 3;
   typedef logic [OCT_BITS-1:0] octant_type;
   localparam octant_type OCT_FIRST = 3'd0;
   localparam octant_type OCT_LAST  = 3'd7;

   // Decision term constants of the midpoint recurrence.
   localparam int DEC_INIT      = 1;
   localparam int DEC_KEEP_STEP = 3;
   localparam int DEC_DIAG_STEP = 5;

   // Jobs that may wait between the step unit and the pixel emitter.
   localparam int JOB_DEPTH = 2;

   // Status of the job queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/midpoint_circle_rasterizer_core.sv
// Midpoint circle generator. A start beat (kind 0) latches center and radius and arms a new
// circle, abandoning any circle still in progress; it yields no pixels. Each step beat
// (kind 1) on an armed circle yields eight pixels in fixed symmetric order, octant 0 to 7,
// the last one of the whole circle flagged; steps on an idle generator are taken and
// dropped. Pixels leave at one per cycle from a single emitter while the pixel side pops;
// up to two steps wait in the job queue while the emitter works, and a step's job passes
// through the job queue and the job register before its first pixel enters the output
// register. Coordinates are two's complement and wrap to COORD_BITS + 2 bits.
module midpoint_circle_rasterizer_core #(
   parameter int COORD_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_kind,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [COORD_BITS-1:0]        req_radius,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic [2:0]                   rsp_octant,
   output logic                         rsp_last_of_circle
);
   import mcr_pkg::*;

   // last, center x, center y, x, y
   localparam int JOB_BITS = 1 + 2 * COORD_BITS + (COORD_BITS + 1) + (COORD_BITS + 2);

   queue_status_type    job_status;
   logic                job_push;
   logic                job_pop;
   logic [JOB_BITS-1:0] job_wr_data;
   logic [JOB_BITS-1:0] job_rd_data;
   octant_type          octant;

   // Step unit: holds the recurrence state and issues one job per step.
   mcr_front #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .job_status   (job_status),
      .job_push     (job_push),
      .job_data     (job_wr_data)
   );

   // Job queue between the step unit and the emitter.
   mcr_job_fifo #(
      .WIDTH (JOB_BITS),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr_data),
      .rd_en   (job_pop),
      .rd_data (job_rd_data),
      .status  (job_status)
   );

   // Emitter: eight pixels per job through an output register.
   mcr_back #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_status         (job_status),
      .job_data           (job_rd_data),
      .job_pop            (job_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_octant         (octant),
      .rsp_last_of_circle (rsp_last_of_circle)
   );

   assign rsp_octant = octant;

endmodule

### rtl/mcr_job_fifo.sv
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_job_fifo #(
   parameter int WIDTH = 45,
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   output logic [WIDTH-1:0]          rd_data,
   output mcr_pkg::queue_status_type status
);
   import mcr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr;
   logic                do_rd;

   // Guard both ends against misuse by the neighbors.
   assign do_wr = wr_en && !status.full;
   assign do_rd = rd_en && !status.empty;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data      = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `MCR_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `MCR_ASSERT_NEXT(a_count_grows, clock, reset, do_wr && !do_rd, count_ff == $past(count_ff) + 1'b1)

endmodule

### rtl/mcr_front.sv
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_front #(
   parameter int COORD_BITS = 10,
   parameter int JOB_BITS   = 4 * COORD_BITS + 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_kind,
   input  logic [COORD_BITS-1:0]     req_center_x,
   input  logic [COORD_BITS-1:0]     req_center_y,
   input  logic [COORD_BITS-1:0]     req_radius,
   input  mcr_pkg::queue_status_type job_status,
   output logic                      job_push,
   output logic [JOB_BITS-1:0]       job_data
);
   import mcr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int YW = COORD_BITS + 2;
   localparam int DW = COORD_BITS + 4;
   localparam int CW = YW + 2;

   logic [XW-1:0]         step_x_ff, step_x_in;
   logic [YW-1:0]         step_y_ff, step_y_in;
   logic [DW-1:0]         decision_ff, decision_in;
   logic [COORD_BITS-1:0] center_x_ff, center_x_in;
   logic [COORD_BITS-1:0] center_y_ff, center_y_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  keep_y;
   logic [DW-1:0]         x_dw;
   logic [DW-1:0]         y_dw;
   logic [DW-1:0]         decision_next;
   logic signed [CW-1:0]  next_x_c;
   logic signed [CW-1:0]  next_y_c;
   logic                  last;

   // Starts only touch local state, but starts and steps alike wait while the job queue is full.
   assign req_full = job_status.full;
   assign accept   = req_push && !req_full;
   assign job_push = accept && (req_kind == KIND_STEP) && active_ff;

   // Midpoint recurrence for the current point.
   assign keep_y        = decision_ff[DW-1];
   assign x_dw          = DW'(step_x_ff);
   assign y_dw          = {{(DW - YW){step_y_ff[YW-1]}}, step_y_ff};
   assign decision_next = keep_y
                        ? decision_ff + (x_dw << 1) + DW'(DEC_KEEP_STEP)
                        : decision_ff + ((x_dw - y_dw) << 1) + DW'(DEC_DIAG_STEP);
   assign next_x_c      = CW'(step_x_ff) + CW'(1);
   assign next_y_c      = {{(CW - YW){step_y_ff[YW-1]}}, step_y_ff} - (keep_y ? CW'(0) : CW'(1));
   assign last          = next_x_c > next_y_c;

   // Job carries the point before the update.
   assign job_data = {last, center_x_ff, center_y_ff, step_x_ff, step_y_ff};

   // State update on start and on a step while a circle runs.
   always_comb begin
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      active_in   = active_ff;
      if (accept && (req_kind == KIND_START)) begin
         step_x_in   = '0;
         step_y_in   = YW'(req_radius);
         decision_in = DW'(DEC_INIT) - DW'(req_radius);
         center_x_in = req_center_x;
         center_y_in = req_center_y;
         active_in   = 1'b1;
      end else if (job_push) begin
         step_x_in   = next_x_c[XW-1:0];
         step_y_in   = next_y_c[YW-1:0];
         decision_in = decision_next;
         active_in   = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         active_ff   <= active_in;
      end
   end

   `MCR_ASSERT_NEXT(a_last_goes_idle, clock, reset, job_push && last, !active_ff)

endmodule

### rtl/mcr_back.sv
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_back #(
   parameter int COORD_BITS = 10,
   parameter int JOB_BITS   = 4 * COORD_BITS + 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mcr_pkg::queue_status_type    job_status,
   input  logic [JOB_BITS-1:0]          job_data,
   output logic                         job_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output mcr_pkg::octant_type          rsp_octant,
   output logic                         rsp_last_of_circle
);
   import mcr_pkg::*;

   localparam int XW = COORD_BITS + 1;
   localparam int YW = COORD_BITS + 2;
   localparam int PW = COORD_BITS + 2;

   logic [JOB_BITS-1:0]   job_ff;
   logic                  busy_ff, busy_in;
   octant_type            oct_ff, oct_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PW-1:0]         pixel_x_ff;
   logic [PW-1:0]         pixel_y_ff;
   octant_type            octant_ff;
   logic                  last_ff;

   logic                  job_last;
   logic [COORD_BITS-1:0] job_cx;
   logic [COORD_BITS-1:0] job_cy;
   logic [XW-1:0]         job_x;
   logic [YW-1:0]         job_y;
   logic                  advance;
   logic                  job_done;
   logic [PW-1:0]         offset_a;
   logic [PW-1:0]         offset_b;
   logic [PW-1:0]         cx_pw;
   logic [PW-1:0]         cy_pw;
   logic [PW-1:0]         pixel_x_in;
   logic [PW-1:0]         pixel_y_in;

   assign {job_last, job_cx, job_cy, job_x, job_y} = job_ff;

   // A beat moves into the output register when it is free or being drained.
   assign advance  = busy_ff && (!out_valid_ff || rsp_pop);
   assign job_done = advance && (oct_ff == OCT_LAST);
   assign job_pop  = !job_status.empty && (!busy_ff || job_done);

   // Octant order: bit 0 negates the x offset and bit 1 the y offset; the last four also swap the axes.
   assign cx_pw      = PW'(job_cx);
   assign cy_pw      = PW'(job_cy);
   assign offset_a   = oct_ff[2] ? job_y : PW'(job_x);
   assign offset_b   = oct_ff[2] ? PW'(job_x) : job_y;
   assign pixel_x_in = oct_ff[0] ? cx_pw - offset_a : cx_pw + offset_a;
   assign pixel_y_in = oct_ff[1] ? cy_pw - offset_b : cy_pw + offset_b;

   // Emitter control.
   always_comb begin
      busy_in      = busy_ff;
      oct_in       = oct_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         oct_in  = OCT_FIRST;
      end else if (job_done) begin
         busy_in = 1'b0;
      end else if (advance) begin
         oct_in = oct_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         oct_ff       <= OCT_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         oct_ff       <= oct_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
      end
      if (advance) begin
         pixel_x_ff <= pixel_x_in;
         pixel_y_ff <= pixel_y_in;
         octant_ff  <= oct_ff;
         last_ff    <= job_last && (oct_ff == OCT_LAST);
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_pixel_x        = pixel_x_ff;
   assign rsp_pixel_y        = pixel_y_ff;
   assign rsp_octant         = octant_ff;
   assign rsp_last_of_circle = last_ff;

   `MCR_ASSERT_SAME(a_last_on_final_octant, clock, reset, out_valid_ff && last_ff, octant_ff == OCT_LAST)
   `MCR_ASSERT_NEXT(a_busy_mid_job, clock, reset, advance && (oct_ff != OCT_LAST), busy_ff)

endmodule

### tb/midpoint_circle_rasterizer_core_test.sv
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_core_test;

   localparam int COORD_BITS = 10;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [COORD_BITS-1:0] EDGE_COORD = COORD_BITS'(COORD_MAX);

   // Tracks the circle generator and holds the pixels it has yet to emit.
   class circle_tracer;

      localparam int CB = COORD_BITS;

      typedef struct {
         logic [CB+1:0]        px;
         logic [CB+1:0]        py;
         mcr_pkg::octant_type  oct;
         logic                 last;
      } circle_pixel_type;

      // Generator state as the block should hold it.
      logic [CB:0]   cur_x;
      logic [CB+1:0] cur_y;
      logic [CB+3:0] dec;
      logic [CB-1:0] ctr_x_q;
      logic [CB-1:0] ctr_y_q;
      bit            armed;

      circle_pixel_type expected_pixels[$];

      int starts;
      int steps_used;
      int steps_ignored;
      int circles_closed;
      int pixels_checked;
      int errors;

      function new();
         cur_x = '0;
         cur_y = '0;
         dec = '0;
         ctr_x_q = '0;
         ctr_y_q = '0;
         armed = 1'b0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function int useful_items();
         return starts + steps_used;
      endfunction

      // Works out the pixels that one accepted beat produces.
      function void rasterize_item(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                   logic [CB-1:0] rad);
         int x, y, d, nx, ny, a, b, px, py;
         circle_pixel_type pix;
         bit closing;

         // A start latches the circle and arms the generator, abandoning any open circle.
         if (kind == mcr_pkg::KIND_START) begin
            ctr_x_q = cx;
            ctr_y_q = cy;
            cur_x = '0;
            cur_y = {2'b00, rad};
            d = mcr_pkg::DEC_INIT - int'(rad);
            dec = d[CB+3:0];
            armed = 1'b1;
            starts++;
            return;
         end
         if (!armed) begin
            steps_ignored++;
            return;
         end
         steps_used++;

         x = int'(cur_x);
         y = int'($signed(cur_y));
         d = int'($signed(dec));

         // Midpoint recurrence: keep y while the decision term is negative, else move inward.
         if (d < 0) begin
            d = d + 2 * x + mcr_pkg::DEC_KEEP_STEP;
            ny = y;
         end else begin
            d = d + 2 * (x - y) + mcr_pkg::DEC_DIAG_STEP;
            ny = y - 1;
         end
         nx = x + 1;
         closing = (nx > ny);

         // Octants 0-3 mirror (x, y), octants 4-7 mirror (y, x); bit 0 negates the x offset
         // and bit 1 the y offset.
         for (int k = 0; k < 8; k++) begin
            a = (k < 4) ? x : y;
            b = (k < 4) ? y : x;
            px = int'(ctr_x_q) + ((k % 2 == 1) ? -a : a);
            py = int'(ctr_y_q) + (((k / 2) % 2 == 1) ? -b : b);
            pix.px = px[CB+1:0];
            pix.py = py[CB+1:0];
            pix.oct = mcr_pkg::octant_type'(k);
            pix.last = closing && (pix.oct == mcr_pkg::OCT_LAST);
            expected_pixels.push_back(pix);
         end

         cur_x = nx[CB:0];
         cur_y = ny[CB+1:0];
         dec = d[CB+3:0];
         if (closing) begin
            armed = 1'b0;
         end
      endfunction

      // Compares one popped pixel with the oldest expected one.
      function void check_pixel(logic [CB+1:0] px, logic [CB+1:0] py,
                                mcr_pkg::octant_type oct, logic last);
         circle_pixel_type want;
         bit bad;

         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 20) begin
               $display("%0t: unexpected pixel x=%0d y=%0d octant=%0d last=%0b", $time,
                        $signed(px), $signed(py), oct, last);
            end
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (want.last) begin
            circles_closed++;
         end
         bad = 1'b0;
         if (px !== want.px) begin
            bad = 1'b1;
            if (errors < 20) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, $signed(want.px),
                        $signed(px));
            end
         end
         if (py !== want.py) begin
            bad = 1'b1;
            if (errors < 20) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, $signed(want.py),
                        $signed(py));
            end
         end
         if (oct !== want.oct) begin
            bad = 1'b1;
            if (errors < 20) begin
               $display("%0t: octant expected %0d actual %0d", $time, want.oct, oct);
            end
         end
         if (last !== want.last) begin
            bad = 1'b1;
            if (errors < 20) begin
               $display("%0t: last_of_circle expected %0b actual %0b", $time, want.last,
                        last);
            end
         end
         if (bad) begin
            errors++;
         end
      endfunction

   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic                         req_kind = mcr_pkg::KIND_STEP;
   logic [COORD_BITS-1:0]        req_center_x = '0;
   logic [COORD_BITS-1:0]        req_center_y = '0;
   logic [COORD_BITS-1:0]        req_radius = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic signed [COORD_BITS+1:0] rsp_pixel_x;
   logic signed [COORD_BITS+1:0] rsp_pixel_y;
   logic [2:0]                   rsp_octant;
   logic                         rsp_last_of_circle;

   circle_tracer tracer = new();

   bit req_steady = 1'b0;
   bit pop_steady = 1'b0;
   int pop_wait = 0;
   int cycles = 0;

   midpoint_circle_rasterizer_core #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_kind(req_kind),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius(req_radius),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_octant(rsp_octant),
      .rsp_last_of_circle(rsp_last_of_circle)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one; none at all in a steady stretch.
   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Random coordinate or radius in the given range.
   function automatic logic [COORD_BITS-1:0] rand_coord(int lo, int hi);
      return COORD_BITS'($urandom_range(lo, hi));
   endfunction

   // Pixel side: pop with random stalls, switching into and out of steady stretches.
   always @(negedge clock) begin
      if ($urandom_range(0, 149) == 0) begin
         pop_steady = !pop_steady;
      end
      if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait = pop_wait - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!pop_steady && $urandom_range(0, 3) == 0) begin
            pop_wait = pick_gap(1'b0);
         end
      end
   end

   // Both handshakes are sampled at the rising edge; the pixel check goes first so that
   // a pixel never meets an expectation from the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            tracer.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_octant, rsp_last_of_circle);
         end
         if (req_push && !req_full) begin
            tracer.rasterize_item(req_kind, req_center_x, req_center_y, req_radius);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still expected", cycles,
                  tracer.pending());
         $display("midpoint_circle_rasterizer_core_test failed");
         $finish;
      end
   end

   // Presents one beat from a falling edge and returns at a falling edge once it is taken.
   task automatic send_item(input logic kind, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy,
                            input logic [COORD_BITS-1:0] rad);
      int gap;
      req_push <= 1'b1;
      req_kind <= kind;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius <= rad;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Step beats carry random coordinates that the block must ignore.
   task automatic send_step();
      send_item(mcr_pkg::KIND_STEP, rand_coord(0, COORD_MAX), rand_coord(0, COORD_MAX),
                rand_coord(0, COORD_MAX));
   endtask

   // Steps the open circle to its end, then sends a few steps that should be dropped.
   task automatic close_circle(input int extra);
      while (tracer.armed) begin
         send_step();
      end
      repeat (extra) send_step();
   endtask

   // Holds the request side off until every expected pixel has been popped.
   task automatic hold_until_drained();
      req_push <= 1'b0;
      while (tracer.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int target;
      int roll;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle step, zero radius, corners, a large circle abandoned mid-way,
      // and a small circle that passes through x equal to y.
      send_step();
      send_item(mcr_pkg::KIND_START, 10'd0, 10'd0, 10'd0);
      close_circle(1);
      send_item(mcr_pkg::KIND_START, EDGE_COORD, EDGE_COORD, 10'd1);
      close_circle(0);
      send_item(mcr_pkg::KIND_START, 10'd0, EDGE_COORD, EDGE_COORD);
      repeat (3) send_step();
      send_item(mcr_pkg::KIND_START, EDGE_COORD, 10'd0, 10'd2);
      close_circle(1);
      send_item(mcr_pkg::KIND_START, 10'd512, 10'd341, 10'd3);
      close_circle(1);
      hold_until_drained();

      // Random: mostly complete circles with random centers, plus abandoned circles,
      // stray beats and full drains.
      target = tracer.useful_items() + 75;
      while (tracer.useful_items() < target) begin
         req_steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 9);
         case (roll)
            6: begin
               send_item(mcr_pkg::KIND_START, rand_coord(0, COORD_MAX),
                         rand_coord(0, COORD_MAX), rand_coord(0, COORD_MAX));
               repeat ($urandom_range(1, 4)) send_step();
            end
            7: begin
               send_item(mcr_pkg::KIND_START, rand_coord(0, COORD_MAX),
                         rand_coord(0, COORD_MAX), rand_coord(4, 30));
               repeat ($urandom_range(1, 2)) send_step();
            end
            8: begin
               repeat ($urandom_range(1, 3)) begin
                  send_item(1'($urandom_range(0, 1)), rand_coord(0, COORD_MAX),
                            rand_coord(0, COORD_MAX), rand_coord(0, COORD_MAX));
               end
            end
            9: begin
               hold_until_drained();
            end
            default: begin
               send_item(mcr_pkg::KIND_START, rand_coord(0, COORD_MAX),
                         rand_coord(0, COORD_MAX),
                         ($urandom_range(0, 4) == 0) ? rand_coord(13, 60)
                                                     : rand_coord(0, 12));
               close_circle(($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
            end
         endcase
      end

      // Wind down: let every pixel out, then watch for strays.
      hold_until_drained();
      repeat (20) @(negedge clock);

      $display("%0d circles started, %0d closed, %0d pixels checked", tracer.starts,
               tracer.circles_closed, tracer.pixels_checked);
      $display("%0d productive steps, %0d steps dropped while idle, %0d cycles",
               tracer.steps_used, tracer.steps_ignored, cycles);
      if (tracer.errors == 0 && tracer.pending() == 0) begin
         $display("midpoint_circle_rasterizer_core_test passed");
      end else begin
         $display("midpoint_circle_rasterizer_core_test failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/mcr_pkg.sv
rtl/mcr_job_fifo.sv
rtl/mcr_front.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_core.sv
tb/midpoint_circle_rasterizer_core_test.sv
